>>> src/lmsd_pkg.sv
// Shared constants, types and position helpers for the lamp matrix scan driver.
package lmsd_pkg;

   // Matrix and shift register geometry
   localparam int ROWS       = 8;
   localparam int COLS       = 5;
   localparam int SHIFT_BITS = 16;

   localparam int LAMPS      = ROWS * COLS;
   localparam int POS_W      = $clog2(LAMPS + 1);
   localparam int LAMP_IDX_W = (LAMPS > 1) ? $clog2(LAMPS) : 1;
   localparam int SLOT_W     = $clog2(2 * SHIFT_BITS);
   localparam int BIT_IDX_W  = $clog2(SHIFT_BITS);

   // Fixed field widths
   localparam int ROW_W   = 3;
   localparam int COL_W   = 3;
   localparam int ROWS_W  = 8;
   localparam int CSR_W   = 16;
   localparam int CSR_IDX_W = 2;

   // Register reset values
   localparam logic [CSR_W-1:0] PULSE_TICKS_RST = 16'd50;
   localparam logic [CSR_W-1:0] SCAN_PERIOD_RST = 16'd2500;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_PERIOD = 2'd1;

   // Item function codes
   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [SHIFT_BITS-1:0] word_type;

   // Row of a row-major lamp position
   function automatic logic [ROW_W-1:0] pos_row(input pos_type pos);
      logic [ROW_W-1:0] row;
      row = '0;
      for (int r = 1; r < ROWS; r++) begin
         if (pos >= POS_W'(r * COLS)) begin
            row = ROW_W'(r);
         end
      end
      return row;
   endfunction

   // Column of a row-major lamp position
   function automatic pos_type pos_col(input pos_type pos);
      logic [ROW_W-1:0] row;
      row = pos_row(pos);
      return pos - POS_W'(row * COLS);
   endfunction

   // Row-major position of a lamp (row and column already range checked)
   function automatic pos_type pos_of(input logic [ROW_W-1:0] row,
                                      input logic [COL_W-1:0] col);
      return POS_W'(row * COLS) + POS_W'(col);
   endfunction

endpackage

>>> src/lamp_matrix_scan_driver_unit.sv
// Top level of the lamp matrix scan driver: lamp map, scan sequencer and result register.
//
// Usage
//   req_*  : one item per handshake. req_func low is one time tick that advances the
//            scan sequencer by one step; req_func high writes one lamp bit of the 8x5
//            map (no time passes, writes outside the matrix are dropped).
//   rsp_*  : one item per request item: serial data, shift clock, latch, row lines and
//            a scan start flag. Data, clock and latch levels hold between ticks.
//   csr_*  : register writes, index 0 = pulse_ticks, 1 = scan_period; other indexes are
//            dropped. csr_ready is always high.
// Latency and throughput
//   Results appear in the cycle after their items are taken. One item is taken
//   every cycle unless stalled: all sequencer work for a tick (start check, next lit
//   lamp search, shift slot, pulse count) is done between inputs and result register.
// Reset
//   Lamp map cleared, registers back to 50 and 2500, all lines low, and the first tick
//   starts a scan.
// Stall
//   While a result waits and rsp_ready is low, req_ready drops; when it is taken, a new
//   request item can be taken in the same cycle.
module lamp_matrix_scan_driver_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_func,
   input  logic [lmsd_pkg::ROW_W-1:0]    req_lamp_row,
   input  logic [lmsd_pkg::COL_W-1:0]    req_lamp_col,
   input  logic                          req_lamp_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_sr_data,
   output logic                          rsp_shift_clk,
   output logic                          rsp_load_strobe,
   output logic [lmsd_pkg::ROWS_W-1:0]   rsp_row_drive,
   output logic                          rsp_scan_start,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lmsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lmsd_pkg::CSR_W-1:0]    csr_wdata
);
   import lmsd_pkg::*;

   // Sequencer phases
   localparam logic [2:0] PH_START     = 3'd0;
   localparam logic [2:0] PH_SHIFT_ON  = 3'd1;
   localparam logic [2:0] PH_LATCH_ON  = 3'd2;
   localparam logic [2:0] PH_PULSE     = 3'd3;
   localparam logic [2:0] PH_SHIFT_OFF = 3'd4;
   localparam logic [2:0] PH_LATCH_OFF = 3'd5;
   localparam logic [2:0] PH_DONE      = 3'd6;
   localparam logic [2:0] PH_SEEK      = 3'd7;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(2 * SHIFT_BITS - 1);

   // State
   logic [CSR_W-1:0]  pulse_ticks_ff, scan_period_ff;
   logic [LAMPS-1:0]  lamp_bits_ff, lamp_bits_in;
   pos_type           scan_pos_ff, scan_pos_in;
   logic [2:0]        phase_ff, phase_in;
   logic [SLOT_W-1:0] bit_slot_ff, bit_slot_in;
   logic [CSR_W-1:0]  pulse_count_ff, pulse_count_in;
   logic [CSR_W-1:0]  period_count_ff, period_count_in;
   word_type          column_word_ff, column_word_in;

   // Result register (data, clock and latch levels double as the held levels)
   logic              rsp_valid_ff, rsp_valid_in;
   logic              sr_data_ff, sr_data_in;
   logic              shift_clk_ff, shift_clk_in;
   logic              load_strobe_ff, load_strobe_in;
   logic [ROWS_W-1:0] row_drive_ff, row_drive_in;
   logic              scan_start_ff, scan_start_in;

   // Scratch for the step logic
   logic              req_take;
   logic              seek_found;
   pos_type           seek_hit;
   pos_type           hit_col;
   logic [BIT_IDX_W-1:0] bit_idx;
   logic [CSR_W-1:0]  pulse_next;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // One sequencer step per tick item, or one lamp map write per write item
   always_comb begin
      lamp_bits_in    = lamp_bits_ff;
      scan_pos_in     = scan_pos_ff;
      phase_in        = phase_ff;
      bit_slot_in     = bit_slot_ff;
      pulse_count_in  = pulse_count_ff;
      period_count_in = period_count_ff;
      column_word_in  = column_word_ff;
      sr_data_in      = sr_data_ff;
      shift_clk_in    = shift_clk_ff;
      load_strobe_in  = load_strobe_ff;
      row_drive_in    = '0;
      scan_start_in   = 1'b0;
      seek_found      = 1'b0;
      seek_hit        = '0;
      hit_col         = '0;
      bit_idx         = '0;
      pulse_next      = '0;

      if (req_func == FUNC_WRITE) begin
         // lamp map write, out-of-range positions dropped
         if (32'(req_lamp_row) < ROWS && 32'(req_lamp_col) < COLS) begin
            lamp_bits_in[LAMP_IDX_W'(pos_of(req_lamp_row, req_lamp_col))] = req_lamp_value;
         end
      end else begin
         // scan start
         if (phase_ff == PH_START ||
             (phase_ff == PH_DONE && period_count_ff >= scan_period_ff)) begin
            scan_start_in   = 1'b1;
            period_count_in = '0;
            scan_pos_in     = '0;
            phase_in        = PH_SEEK;
         end
         if (period_count_in != '1) begin
            period_count_in = period_count_in + 1'b1;
         end

         // next lit lamp at or after the current position
         if (phase_in == PH_SEEK) begin
            for (int i = 0; i < LAMPS; i++) begin
               if (!seek_found && POS_W'(i) >= scan_pos_in && lamp_bits_ff[i]) begin
                  seek_found = 1'b1;
                  seek_hit   = POS_W'(i);
               end
            end
            if (seek_found) begin
               scan_pos_in    = seek_hit;
               hit_col        = pos_col(seek_hit);
               column_word_in = (32'(hit_col) < SHIFT_BITS) ?
                                (word_type'(1) << hit_col) : '0;
               bit_slot_in    = '0;
               phase_in       = PH_SHIFT_ON;
            end else begin
               scan_pos_in = POS_W'(LAMPS);
               phase_in    = PH_DONE;
            end
         end

         bit_idx    = BIT_IDX_W'(SHIFT_BITS - 1) - BIT_IDX_W'(bit_slot_in >> 1);
         pulse_next = pulse_count_ff + 1'b1;

         case (phase_in)
            PH_SHIFT_ON, PH_SHIFT_OFF: begin
               // one half bit: clock low with data, then clock high
               sr_data_in     = (phase_in == PH_SHIFT_ON) ? column_word_in[bit_idx] : 1'b0;
               shift_clk_in   = bit_slot_in[0];
               load_strobe_in = 1'b0;
               if (bit_slot_in == SLOT_LAST) begin
                  bit_slot_in = '0;
                  phase_in    = (phase_in == PH_SHIFT_ON) ? PH_LATCH_ON : PH_LATCH_OFF;
               end else begin
                  bit_slot_in = bit_slot_in + 1'b1;
               end
            end
            PH_LATCH_ON: begin
               shift_clk_in   = 1'b1;
               load_strobe_in = 1'b1;
               sr_data_in     = column_word_ff[0];
               pulse_count_in = '0;
               phase_in       = PH_PULSE;
            end
            PH_PULSE: begin
               shift_clk_in   = 1'b1;
               load_strobe_in = 1'b1;
               sr_data_in     = column_word_ff[0];
               row_drive_in   = ROWS_W'(1) << pos_row(scan_pos_ff);
               pulse_count_in = pulse_next;
               if (pulse_next >= pulse_ticks_ff) begin
                  column_word_in = '0;
                  bit_slot_in    = '0;
                  phase_in       = PH_SHIFT_OFF;
               end
            end
            PH_LATCH_OFF: begin
               shift_clk_in   = 1'b1;
               load_strobe_in = 1'b1;
               sr_data_in     = 1'b0;
               scan_pos_in    = scan_pos_ff + 1'b1;
               phase_in       = PH_SEEK;
            end
            default: begin
            end
         endcase
      end
   end

   // Result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Registers and state
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ticks_ff  <= PULSE_TICKS_RST;
         scan_period_ff  <= SCAN_PERIOD_RST;
         lamp_bits_ff    <= '0;
         scan_pos_ff     <= '0;
         phase_ff        <= PH_START;
         bit_slot_ff     <= '0;
         pulse_count_ff  <= '0;
         period_count_ff <= '0;
         column_word_ff  <= '0;
         rsp_valid_ff    <= 1'b0;
         sr_data_ff      <= 1'b0;
         shift_clk_ff    <= 1'b0;
         load_strobe_ff  <= 1'b0;
         row_drive_ff    <= '0;
         scan_start_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_PULSE_TICKS: pulse_ticks_ff <= csr_wdata;
               CSR_SCAN_PERIOD: scan_period_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            lamp_bits_ff    <= lamp_bits_in;
            scan_pos_ff     <= scan_pos_in;
            phase_ff        <= phase_in;
            bit_slot_ff     <= bit_slot_in;
            pulse_count_ff  <= pulse_count_in;
            period_count_ff <= period_count_in;
            column_word_ff  <= column_word_in;
            sr_data_ff      <= sr_data_in;
            shift_clk_ff    <= shift_clk_in;
            load_strobe_ff  <= load_strobe_in;
            row_drive_ff    <= row_drive_in;
            scan_start_ff   <= scan_start_in;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sr_data     = sr_data_ff;
   assign rsp_shift_clk   = shift_clk_ff;
   assign rsp_load_strobe = load_strobe_ff;
   assign rsp_row_drive   = row_drive_ff;
   assign rsp_scan_start  = scan_start_ff;

   // Checks
   a_row_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(row_drive_ff))
      else $error("more than one row driven");

   a_row_latched: assert property (@(posedge clock) disable iff (reset)
      (row_drive_ff != '0) |-> (load_strobe_ff && shift_clk_ff))
      else $error("row driven while shifting");

   a_start_no_row: assert property (@(posedge clock) disable iff (reset)
      scan_start_ff |-> (row_drive_ff == '0))
      else $error("row driven on scan start");

   a_slot_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_SHIFT_ON && phase_ff != PH_SHIFT_OFF) |-> (bit_slot_ff == '0))
      else $error("bit slot left nonzero outside shifting");

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("taken item produced no result");

endmodule

>>> tb/sv/tb_lamp_matrix_scan_driver_unit.sv
// Self-checking testbench for the lamp matrix scan driver, with its own scan sequencer model.
module tb_lamp_matrix_scan_driver_unit;
   import lmsd_pkg::*;

   // Register indexes the block drops
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam int MAX_SHOWN = 10;

   typedef enum logic [2:0] {
      SEQ_START, SEQ_SHIFT_ON, SEQ_LATCH_ON, SEQ_PULSE,
      SEQ_SHIFT_OFF, SEQ_LATCH_OFF, SEQ_DONE, SEQ_SEEK
   } seq_phase_type;

   typedef struct packed {
      logic              sr_data;
      logic              shift_clk;
      logic              load_strobe;
      logic [ROWS_W-1:0] row_drive;
      logic              scan_start;
   } lamp_lines_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_func;
   logic [ROW_W-1:0]     req_lamp_row;
   logic [COL_W-1:0]     req_lamp_col;
   logic                 req_lamp_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_sr_data;
   logic                 rsp_shift_clk;
   logic                 rsp_load_strobe;
   logic [ROWS_W-1:0]    rsp_row_drive;
   logic                 rsp_scan_start;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   lamp_matrix_scan_driver_unit DUT (.*);

   // Sequencer model state
   logic [COLS-1:0] lamp_map [ROWS];
   seq_phase_type   seq_phase;
   int unsigned     seq_pos;
   int unsigned     seq_slot;
   int unsigned     pulse_cnt;
   int unsigned     period_cnt;
   word_type        col_word;
   logic            hold_data, hold_clock, hold_latch;
   logic [CSR_W-1:0] cfg_pulse, cfg_period;

   lamp_lines_type lines_due[$];
   int             mismatch_count;
   bit             idle_on;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #(12 * 200000);
      $display("lamp_matrix_scan_driver_unit: mismatch");
      $finish;
   end

   function automatic void reset_scanner();
      foreach (lamp_map[r]) lamp_map[r] = '0;
      seq_phase  = SEQ_START;
      seq_pos    = 0;
      seq_slot   = 0;
      pulse_cnt  = 0;
      period_cnt = 0;
      col_word   = '0;
      hold_data  = 1'b0;
      hold_clock = 1'b0;
      hold_latch = 1'b0;
      cfg_pulse  = PULSE_TICKS_RST;
      cfg_period = SCAN_PERIOD_RST;
   endfunction

   // One shift slot: even slots put data with clock low, odd slots raise the clock
   function automatic logic shift_out_slot(input word_type w);
      int unsigned bit_idx;
      bit_idx    = SHIFT_BITS - 1 - (seq_slot >> 1);
      hold_data  = w[bit_idx];
      hold_clock = seq_slot[0];
      hold_latch = 1'b0;
      seq_slot++;
      if (seq_slot >= 2 * SHIFT_BITS) begin
         seq_slot = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Expected lines for one item; updates the model state
   function automatic lamp_lines_type advance_scanner(input logic func,
                                                      input logic [ROW_W-1:0] row,
                                                      input logic [COL_W-1:0] col,
                                                      input logic value);
      lamp_lines_type res;
      logic [ROWS_W-1:0] rows_on;
      logic started;
      int unsigned c;
      rows_on = '0;
      started = 1'b0;
      if (func == FUNC_WRITE) begin
         if (row < ROWS && col < COLS) begin
            lamp_map[row][col] = value;
         end
      end else begin
         if (seq_phase == SEQ_START || (seq_phase == SEQ_DONE && period_cnt >= cfg_period)) begin
            started    = 1'b1;
            period_cnt = 0;
            seq_pos    = 0;
            seq_phase  = SEQ_SEEK;
         end
         if (period_cnt < 32'hFFFF) period_cnt++;
         // find next lit lamp in row-major order
         if (seq_phase == SEQ_SEEK) begin
            while (seq_pos < LAMPS && !lamp_map[seq_pos / COLS][seq_pos % COLS]) seq_pos++;
            if (seq_pos < LAMPS) begin
               c        = seq_pos % COLS;
               col_word = '0;
               if (c < SHIFT_BITS) col_word[c] = 1'b1;
               seq_slot  = 0;
               seq_phase = SEQ_SHIFT_ON;
            end else begin
               seq_phase = SEQ_DONE;
            end
         end
         case (seq_phase)
            SEQ_SHIFT_ON: begin
               if (shift_out_slot(col_word)) seq_phase = SEQ_LATCH_ON;
            end
            SEQ_LATCH_ON: begin
               hold_clock = 1'b1;
               hold_latch = 1'b1;
               hold_data  = col_word[0];
               pulse_cnt  = 0;
               seq_phase  = SEQ_PULSE;
            end
            SEQ_PULSE: begin
               hold_clock = 1'b1;
               hold_latch = 1'b1;
               hold_data  = col_word[0];
               rows_on    = ROWS_W'(1) << ((seq_pos / COLS) & 7);
               pulse_cnt++;
               if (pulse_cnt >= cfg_pulse) begin
                  col_word  = '0;
                  seq_slot  = 0;
                  seq_phase = SEQ_SHIFT_OFF;
               end
            end
            SEQ_SHIFT_OFF: begin
               if (shift_out_slot('0)) seq_phase = SEQ_LATCH_OFF;
            end
            SEQ_LATCH_OFF: begin
               hold_clock = 1'b1;
               hold_latch = 1'b1;
               hold_data  = 1'b0;
               seq_pos++;
               seq_phase = SEQ_SEEK;
            end
            default: ;
         endcase
      end
      res.sr_data     = hold_data;
      res.shift_clk   = hold_clock;
      res.load_strobe = hold_latch;
      res.row_drive   = rows_on;
      res.scan_start  = started;
      return res;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [CSR_W-1:0] data);
      if (idx == CSR_PULSE_TICKS) cfg_pulse = data;
      else if (idx == CSR_SCAN_PERIOD) cfg_period = data;
   endfunction

   // Compare one result item with the oldest expectation
   function automatic void check_lines(input lamp_lines_type got);
      lamp_lines_type want;
      bit bad;
      if (lines_due.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= MAX_SHOWN)
            $display("unexpected item: data %b clock %b latch %b rows %h start %b",
                     got.sr_data, got.shift_clk, got.load_strobe, got.row_drive,
                     got.scan_start);
         return;
      end
      want = lines_due.pop_front();
      bad  = (got.sr_data !== want.sr_data) || (got.shift_clk !== want.shift_clk)
          || (got.load_strobe !== want.load_strobe) || (got.row_drive !== want.row_drive)
          || (got.scan_start !== want.scan_start);
      if (bad) begin
         mismatch_count++;
         if (mismatch_count <= MAX_SHOWN)
            $display("t=%0t exp data %b clock %b latch %b rows %h start %b / got %b %b %b %h %b",
                     $realtime, want.sr_data, want.shift_clk, want.load_strobe, want.row_drive,
                     want.scan_start, got.sr_data, got.shift_clk, got.load_strobe,
                     got.row_drive, got.scan_start);
      end
   endfunction

   // Monitor: results first, then register writes, then new items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            check_lines({rsp_sr_data, rsp_shift_clk, rsp_load_strobe, rsp_row_drive,
                         rsp_scan_start});
         if (csr_valid && csr_ready) apply_reg_write(csr_index, csr_wdata);
         if (req_valid && req_ready)
            lines_due.push_back(advance_scanner(req_func, req_lamp_row, req_lamp_col,
                                                req_lamp_value));
      end
   end

   // Result side back-pressure in random bursts
   initial begin : rsp_stall_gen
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 7);
         if (stall_left > 0 && idle_on) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            stall_left = 0;
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic func, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic value);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= func;
      req_lamp_row   <= row;
      req_lamp_col   <= col;
      req_lamp_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic run_ticks(input int n);
      repeat (n) send_item(FUNC_TICK, ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
   endtask

   // Mostly ticks, some lamp writes with full-range row and column
   task automatic send_random_item(input int write_pct);
      if ($urandom_range(0, 99) < write_pct)
         send_item(FUNC_WRITE, ROW_W'($urandom_range(0, 7)), COL_W'($urandom_range(0, 7)),
                   $urandom_range(0, 2) != 0);
      else
         send_item(FUNC_TICK, ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
   endtask

   // Hold off the sender until all results are back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (lines_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Empty map: start tick is idle with scan_start, out-of-range columns dropped
   task automatic test_empty_map();
      run_ticks(4);
      send_item(FUNC_WRITE, 3'd7, 3'd5, 1'b1);
      send_item(FUNC_WRITE, 3'd0, 3'd6, 1'b1);
      send_item(FUNC_WRITE, 3'd3, 3'd7, 1'b1);
      run_ticks(2);
   endtask

   // Corner lamps with zero pulse and zero period: overrun restart, writes mid-shift
   task automatic test_corner_lamps();
      drain_results();
      write_reg(CSR_PULSE_TICKS, 16'd0);
      write_reg(CSR_SCAN_PERIOD, 16'd0);
      send_item(FUNC_WRITE, 3'd0, 3'd0, 1'b1);
      send_item(FUNC_WRITE, 3'd7, 3'd4, 1'b1);
      run_ticks(10);
      send_item(FUNC_WRITE, 3'd2, 3'd3, 1'b0);
      run_ticks(130);
      send_item(FUNC_WRITE, 3'd0, 3'd0, 1'b0);
      send_item(FUNC_WRITE, 3'd7, 3'd4, 1'b0);
      run_ticks(70);
   endtask

   // Register extremes and the dropped indexes
   task automatic test_register_extremes();
      drain_results();
      write_reg(CSR_PULSE_TICKS, 16'hFFFF);
      write_reg(CSR_SCAN_PERIOD, 16'hFFFF);
      write_reg(CSR_SPARE_A, 16'h0000);
      write_reg(CSR_SPARE_B, 16'hFFFF);
      send_item(FUNC_WRITE, 3'd4, 3'd2, 1'b1);
      run_ticks(120);
      drain_results();
      write_reg(CSR_PULSE_TICKS, 16'd1);
      write_reg(CSR_SCAN_PERIOD, 16'd1);
      run_ticks(80);
      send_item(FUNC_WRITE, 3'd4, 3'd2, 1'b0);
      run_ticks(3);
   endtask

   // Random scans under several short settings
   task automatic test_random_scans(input int phases, input int per_phase);
      for (int p = 0; p < phases; p++) begin
         drain_results();
         write_reg(CSR_PULSE_TICKS, CSR_W'($urandom_range(0, 8)));
         write_reg(CSR_SCAN_PERIOD,
                   ($urandom_range(0, 3) == 0) ? 16'd0 : CSR_W'($urandom_range(1, 400)));
         repeat (per_phase) send_random_item(12);
      end
   endtask

   // Closing stretch with no gaps or stalls
   task automatic test_unbroken_stream(input int n);
      drain_results();
      idle_on = 1'b0;
      repeat (n) send_random_item(12);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_TICK;
      req_lamp_row   = '0;
      req_lamp_col   = '0;
      req_lamp_value = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_PULSE_TICKS;
      csr_wdata      = '0;
      idle_on        = 1'b1;
      mismatch_count = 0;
      reset_scanner();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_map();
      test_corner_lamps();
      test_register_extremes();
      test_random_scans(4, 30);
      test_unbroken_stream(100);

      drain_results();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("lamp_matrix_scan_driver_unit: match");
      end else begin
         $display("lamp_matrix_scan_driver_unit: mismatch");
      end
      $finish;
   end

endmodule
